// ----- rtl/core/dmv_pkg.sv -----
// ----------------------------------------------------------------------------
// dmv_pkg
// shared sizes, codes, types and arithmetic helpers of the matrix-vector mac
// ----------------------------------------------------------------------------
`default_nettype none

package dmv_pkg;

    localparam int MAX_DIM       = 16;
    localparam int VALUE_BITS    = 32;
    localparam int FRAC_BITS     = 16;
    localparam int FIELD_BITS    = 32;
    localparam int KIND_BITS     = 2;
    localparam int IDX_BITS      = $clog2(MAX_DIM);
    localparam int CFG_BITS      = 5;
    localparam int DEPTH         = MAX_DIM * MAX_DIM;
    localparam int ADDR_BITS     = $clog2(DEPTH);
    localparam int SIZE_RESET    = 16;
    localparam int PADDR_BITS    = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int PROD_BITS     = 2 * VALUE_BITS;

    // width of one shifted product, and of the running row sum
    localparam int TERM_BITS = (PROD_BITS - FRAC_BITS > VALUE_BITS) ?
                               (PROD_BITS - FRAC_BITS) : VALUE_BITS;
    localparam int ACC_BITS  = TERM_BITS + $clog2(MAX_DIM) + 1;

    localparam logic signed [63:0] VAL_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VAL_MIN = -VAL_MAX - 64'sd1;

    // register index, as decoded from paddr bit 2
    localparam logic [0:0] REG_ROWS = 1'b0;
    localparam logic [0:0] REG_COLS = 1'b1;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ACC  = 2'd0,
        KIND_READ = 2'd1,
        KIND_VEC  = 2'd2,
        KIND_ROW  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ROW,
        S_DRAIN,
        S_PUT
    } state_t;

    // control broadcast from the sequencer to every cell of the chain
    typedef struct packed {
        logic                vec_we;
        logic [IDX_BITS-1:0] vec_col;
        logic                mvalid;
        logic [IDX_BITS-1:0] mcol;
        logic                skip;
        logic [IDX_BITS-1:0] row;
    } cell_ctrl_t;

    function automatic logic [CFG_BITS-1:0] eff_size(input logic [CFG_BITS-1:0] v);
        logic [CFG_BITS-1:0] r;
        priority if (v == '0)
            r = CFG_BITS'(1);
        else if (v > CFG_BITS'(MAX_DIM))
            r = CFG_BITS'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] sat_value(input logic signed [63:0] v);
        logic signed [VALUE_BITS-1:0] r;
        priority if (v > VAL_MAX)
            r = VALUE_BITS'(VAL_MAX);
        else if (v < VAL_MIN)
            r = VALUE_BITS'(VAL_MIN);
        else
            r = VALUE_BITS'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dmv_cmd_if.sv -----
// ----------------------------------------------------------------------------
// dmv_cmd_if
// command channel: one word per command, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dmv_cmd_if;

    logic                                valid;
    logic                                ready;
    logic [dmv_pkg::KIND_BITS-1:0]       kind;
    logic [dmv_pkg::IDX_BITS-1:0]        row;
    logic [dmv_pkg::IDX_BITS-1:0]        col;
    logic signed [dmv_pkg::FIELD_BITS-1:0] entry_value;
    logic                                skip_diagonal;

    modport source (
        output valid, kind, row, col, entry_value, skip_diagonal,
        input  ready
    );

    modport sink (
        input  valid, kind, row, col, entry_value, skip_diagonal,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/core/dmv_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dmv_rsp_if
// response channel: one word per command, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface dmv_rsp_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [dmv_pkg::FIELD_BITS-1:0] result_value;
    logic                                  index_error;

    modport source (
        output valid, result_value, index_error,
        input  ready
    );

    modport sink (
        input  valid, result_value, index_error,
        output ready
    );

endinterface

`default_nettype wire

// ----- rtl/core/dense_matrix_vector_mac_top.sv -----
// ----------------------------------------------------------------------------
// dense_matrix_vector_mac_top
// dense matrix store plus input vector, with a chain of column cells that
// forms one row product at a time
//
// channels: cmd takes one command word (kind, row, col, entry_value,
// skip_diagonal); rsp returns one word per command (result_value,
// index_error). an apb port holds rows_in_use at 0x0 and cols_in_use at 0x4,
// to be written only while no command is in flight.
// path from cmd accept to rsp valid: a vector load or an index error goes
// through the put state, an entry accumulate or read through the read and put
// states, a row product through the row, drain and put states. the row
// product time is set by the sum token walking all MAX_DIM cells after the
// matrix row is streamed out of the single read port; the chain always runs
// its full length whatever cols_in_use is. one command is in work at a time:
// the next command is taken in the cycle that the previous response first
// shows valid.
// the rsp output register lets the next command be accepted while a
// response waits; a further response holds the sequencer until rsp is free.
// reset clears the per-entry valid bits of the matrix store at once (entries
// read as zero until written) and sets both sizes to 16; vector elements
// stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module dense_matrix_vector_mac_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    dmv_cmd_if.sink                              cmd,
    dmv_rsp_if.source                            rsp,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dmv_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [dmv_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [dmv_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);

    // ---------------------------------------------------------------- config
    logic [dmv_pkg::CFG_BITS-1:0] rows_reg;
    logic [dmv_pkg::CFG_BITS-1:0] cols_reg;
    logic [dmv_pkg::CFG_BITS-1:0] nr;
    logic [dmv_pkg::CFG_BITS-1:0] nc;
    logic                         cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= dmv_pkg::CFG_BITS'(dmv_pkg::SIZE_RESET);
            cols_reg <= dmv_pkg::CFG_BITS'(dmv_pkg::SIZE_RESET);
        end
        else if (cfg_we)
        begin
            if (paddr[2] == dmv_pkg::REG_COLS)
                cols_reg <= pwdata[dmv_pkg::CFG_BITS-1:0];
            else
                rows_reg <= pwdata[dmv_pkg::CFG_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == dmv_pkg::REG_COLS) ?
                    dmv_pkg::APB_DATA_BITS'(cols_reg) :
                    dmv_pkg::APB_DATA_BITS'(rows_reg);

    // sizes as used: clamped to 1..MAX_DIM
    assign nr = dmv_pkg::eff_size(rows_reg);
    assign nc = dmv_pkg::eff_size(cols_reg);

    // --------------------------------------------------------- command decode
    localparam int AW2 = dmv_pkg::ADDR_BITS + 2;

    dmv_pkg::state_t                       state_reg;
    dmv_pkg::state_t                       state_next;
    logic                                  accept;
    logic                                  in_err;
    logic                                  row_err;
    logic                                  col_err;
    logic signed [dmv_pkg::VALUE_BITS-1:0] in_val;
    logic [dmv_pkg::ADDR_BITS-1:0]         acc_addr;
    logic [AW2-1:0]                        col_off;

    assign cmd.ready = (state_reg == dmv_pkg::S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign in_val    = dmv_pkg::sat_value(64'(cmd.entry_value));
    assign row_err   = ({1'b0, cmd.row} >= nr);
    assign col_err   = ({1'b0, cmd.col} >= nc);

    always_comb
    begin
        unique case (dmv_pkg::kind_t'(cmd.kind))
            dmv_pkg::KIND_ACC,
            dmv_pkg::KIND_READ: in_err = row_err || col_err;
            dmv_pkg::KIND_VEC:  in_err = col_err;
            dmv_pkg::KIND_ROW:  in_err = row_err;
            default:            in_err = 1'b1;
        endcase
    end

    // row-major address; a row product starts from the row base
    assign col_off  = (dmv_pkg::kind_t'(cmd.kind) == dmv_pkg::KIND_ROW) ? '0 : AW2'(cmd.col);
    assign acc_addr = dmv_pkg::ADDR_BITS'(AW2'(cmd.row) * AW2'(nc) + col_off);

    // command fields held for the sequencer
    dmv_pkg::kind_t                        kind_reg;
    logic [dmv_pkg::IDX_BITS-1:0]          row_reg;
    logic                                  skip_reg;
    logic signed [dmv_pkg::VALUE_BITS-1:0] val_reg;
    logic [dmv_pkg::ADDR_BITS-1:0]         addr_reg;
    logic [dmv_pkg::IDX_BITS-1:0]          last_col_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= dmv_pkg::kind_t'(cmd.kind);
            row_reg      <= cmd.row;
            skip_reg     <= cmd.skip_diagonal;
            val_reg      <= in_val;
            addr_reg     <= acc_addr;
            last_col_reg <= dmv_pkg::IDX_BITS'(nc - dmv_pkg::CFG_BITS'(1));
        end
    end

    // ----------------------------------------------------------- matrix store
    logic signed [dmv_pkg::VALUE_BITS-1:0] mem [dmv_pkg::DEPTH];
    logic [dmv_pkg::DEPTH-1:0]             vld_reg;
    logic signed [dmv_pkg::VALUE_BITS-1:0] mem_q;
    logic                                  vld_q;
    logic                                  mem_we;
    logic [dmv_pkg::ADDR_BITS-1:0]         mem_raddr;
    logic signed [dmv_pkg::VALUE_BITS-1:0] mdata;
    logic signed [dmv_pkg::VALUE_BITS-1:0] rmw_sum;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= rmw_sum;
        end
        mem_q <= mem[mem_raddr];
    end

    // an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vld_q   <= 1'b0;
        end
        else
        begin
            if (mem_we)
                vld_reg[addr_reg] <= 1'b1;
            vld_q <= vld_reg[mem_raddr];
        end
    end

    assign mdata   = vld_q ? mem_q : '0;
    assign rmw_sum = dmv_pkg::sat_value(64'(mdata) + 64'(val_reg));

    // -------------------------------------------------------------- sequencer
    logic [dmv_pkg::IDX_BITS-1:0]          j_reg;
    logic [dmv_pkg::IDX_BITS-1:0]          j_next;
    logic signed [dmv_pkg::VALUE_BITS-1:0] res_reg;
    logic signed [dmv_pkg::VALUE_BITS-1:0] res_next;
    logic                                  err_reg;
    logic                                  err_next;
    logic                                  vec_we;
    logic                                  out_load;
    logic                                  tok_last;
    logic signed [dmv_pkg::ACC_BITS-1:0]   sum_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dmv_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        res_next   = res_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        mem_raddr  = acc_addr;
        vec_we     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            dmv_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    j_next = '0;
                    if (in_err)
                    begin
                        res_next   = '0;
                        err_next   = 1'b1;
                        state_next = dmv_pkg::S_PUT;
                    end
                    else
                    begin
                        unique case (dmv_pkg::kind_t'(cmd.kind))
                            dmv_pkg::KIND_ACC,
                            dmv_pkg::KIND_READ: state_next = dmv_pkg::S_READ;
                            dmv_pkg::KIND_VEC:
                            begin
                                vec_we     = 1'b1;
                                res_next   = in_val;
                                err_next   = 1'b0;
                                state_next = dmv_pkg::S_PUT;
                            end
                            dmv_pkg::KIND_ROW:  state_next = dmv_pkg::S_ROW;
                            default:            state_next = dmv_pkg::S_IDLE;
                        endcase
                    end
                end
            end
            dmv_pkg::S_READ:
            begin
                // read data of the entry is on mem_q now
                err_next = 1'b0;
                if (kind_reg == dmv_pkg::KIND_ACC)
                begin
                    mem_we   = 1'b1;
                    res_next = rmw_sum;
                end
                else
                begin
                    res_next = mdata;
                end
                state_next = dmv_pkg::S_PUT;
            end
            dmv_pkg::S_ROW:
            begin
                // stream the row out, one column a cycle
                mem_raddr = dmv_pkg::ADDR_BITS'(addr_reg + dmv_pkg::ADDR_BITS'(j_reg));
                j_next    = j_reg + dmv_pkg::IDX_BITS'(1);
                if (j_reg == last_col_reg)
                    state_next = dmv_pkg::S_DRAIN;
            end
            dmv_pkg::S_DRAIN:
            begin
                if (tok_last)
                begin
                    res_next   = dmv_pkg::sat_value(64'(sum_last));
                    err_next   = 1'b0;
                    state_next = dmv_pkg::S_PUT;
                end
            end
            dmv_pkg::S_PUT:
            begin
                if (!rsp.valid || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = dmv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dmv_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        j_reg   <= j_next;
        res_reg <= res_next;
        err_reg <= err_next;
    end

    // ------------------------------------------------------------ cell chain
    // column j is on the bus in the cycle before the sum token reaches cell j,
    // so each cell has its product registered exactly when the token passes
    logic                                  bus_valid_reg;
    logic [dmv_pkg::IDX_BITS-1:0]          bus_col_reg;
    logic                                  launch_reg;
    dmv_pkg::cell_ctrl_t                   ctrl;
    logic                                  tok  [dmv_pkg::MAX_DIM+1];
    logic signed [dmv_pkg::ACC_BITS-1:0]   sum  [dmv_pkg::MAX_DIM+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_valid_reg <= 1'b0;
            launch_reg    <= 1'b0;
        end
        else
        begin
            bus_valid_reg <= (state_reg == dmv_pkg::S_ROW);
            launch_reg    <= bus_valid_reg && (bus_col_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        bus_col_reg <= j_reg;
    end

    assign ctrl.vec_we  = vec_we;
    assign ctrl.vec_col = cmd.col;
    assign ctrl.mvalid  = bus_valid_reg;
    assign ctrl.mcol    = bus_col_reg;
    assign ctrl.skip    = skip_reg;
    assign ctrl.row     = row_reg;

    // addend enters with the token; skip_diagonal drops it
    assign tok[0] = launch_reg;
    assign sum[0] = skip_reg ? '0 : dmv_pkg::ACC_BITS'(val_reg);

    for (genvar i = 0; i < dmv_pkg::MAX_DIM; i++)
    begin : g_cell
        dmv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (dmv_pkg::IDX_BITS'(i)),
            .ctrl      (ctrl),
            .vec_wdata (in_val),
            .mdata     (mdata),
            .tok_in    (tok[i]),
            .sum_in    (sum[i]),
            .tok_out   (tok[i+1]),
            .sum_out   (sum[i+1])
        );
    end

    assign tok_last = tok[dmv_pkg::MAX_DIM];
    assign sum_last = sum[dmv_pkg::MAX_DIM];

    // ---------------------------------------------------------- output word
    logic                                  out_valid_reg;
    logic signed [dmv_pkg::FIELD_BITS-1:0] out_value_reg;
    logic                                  out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg <= dmv_pkg::FIELD_BITS'(res_reg);
            out_err_reg   <= err_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.index_error  = out_err_reg;

    // ------------------------------------------------------------ assertions
    // the row sum leaves the chain only while the sequencer waits for it
    a_tok_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last |-> (state_reg == dmv_pkg::S_DRAIN))
        else $error("row sum left the chain outside the drain state");

    // exactly one sum token is launched per row
    a_single_launch: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |=> !launch_reg)
        else $error("second sum token launched back to back");

    // the entry read state is only entered right after a command accept
    a_read_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmv_pkg::S_READ) |-> $past(accept))
        else $error("entry read state without a preceding accept");

endmodule

`default_nettype wire

// ----- rtl/core/dmv_cell.sv -----
// ----------------------------------------------------------------------------
// dmv_cell
// one column cell: holds a vector element, multiplies it with the matrix
// entry of its column and adds the term into the row sum passing through
// ----------------------------------------------------------------------------
`default_nettype none

module dmv_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic [dmv_pkg::IDX_BITS-1:0]           cell_idx,
    input  dmv_pkg::cell_ctrl_t                    ctrl,
    input  logic signed [dmv_pkg::VALUE_BITS-1:0]  vec_wdata,
    input  logic signed [dmv_pkg::VALUE_BITS-1:0]  mdata,
    input  logic                                   tok_in,
    input  logic signed [dmv_pkg::ACC_BITS-1:0]    sum_in,
    output logic                                   tok_out,
    output logic signed [dmv_pkg::ACC_BITS-1:0]    sum_out
);

    logic signed [dmv_pkg::VALUE_BITS-1:0] vec_reg;
    logic signed [dmv_pkg::PROD_BITS-1:0]  prod_reg;
    logic signed [dmv_pkg::PROD_BITS-1:0]  prod_next;
    logic                                  pv_reg;
    logic                                  pv_next;
    logic                                  tok_reg;
    logic signed [dmv_pkg::ACC_BITS-1:0]   sum_reg;
    logic signed [dmv_pkg::ACC_BITS-1:0]   sum_next;
    logic signed [dmv_pkg::ACC_BITS-1:0]   term;

    assign prod_next = dmv_pkg::PROD_BITS'(mdata) * dmv_pkg::PROD_BITS'(vec_reg);

    // this cell's column is on the bus, and it is not a skipped diagonal
    assign pv_next = ctrl.mvalid && (ctrl.mcol == cell_idx) &&
                     !(ctrl.skip && (ctrl.row == cell_idx));

    // arithmetic shift floors toward minus infinity
    assign term     = dmv_pkg::ACC_BITS'(prod_reg >>> dmv_pkg::FRAC_BITS);
    assign sum_next = sum_in + (pv_reg ? term : '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.vec_we && (ctrl.vec_col == cell_idx))
        begin
            vec_reg <= vec_wdata;
        end
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= 1'b0;
            tok_reg <= 1'b0;
        end
        else
        begin
            pv_reg  <= pv_next;
            tok_reg <= tok_in;
        end
    end

    assign tok_out = tok_reg;
    assign sum_out = sum_reg;

endmodule

`default_nettype wire

// ----- tb/dense_matrix_vector_mac_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dense_matrix_vector_mac_top_tb
// self-checking bench for the dense matrix-vector mac: a queue-fed driver
// offers command words with random gaps, a clocked monitor predicts every
// accepted word in q16.16 and checks each response word against the oldest
// prediction, across several matrix size settings written over apb
// ----------------------------------------------------------------------------
module dense_matrix_vector_mac_top_tb;

    localparam int WATCHDOG_LIMIT = 4000;       // handshake-free cycles before giving up
    localparam int HOLD_CYCLES    = 400;        // long response back-pressure stretch
    localparam int SETTLE_CYCLES  = dmv_pkg::MAX_DIM + 8; // a bit beyond the row product latency
    localparam int GAP_MAX        = 13;
    localparam int REPORT_MAX     = 10;

    typedef struct packed {
        dmv_pkg::kind_t                        kind;
        logic [dmv_pkg::IDX_BITS-1:0]          row;
        logic [dmv_pkg::IDX_BITS-1:0]          col;
        logic signed [dmv_pkg::FIELD_BITS-1:0] value;
        logic                                  skip;
    } mac_word_t;

    typedef struct packed {
        logic signed [dmv_pkg::FIELD_BITS-1:0] value;
        logic                                  err;
    } mac_result_t;

    // ------------------------------------------------------------------------
    // clock, reset, dut
    // ------------------------------------------------------------------------
    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [dmv_pkg::PADDR_BITS-1:0]    paddr;
    logic [dmv_pkg::APB_DATA_BITS-1:0] pwdata;
    logic [dmv_pkg::APB_DATA_BITS-1:0] prdata;
    logic                              pready;

    dmv_cmd_if cmd_ch ();
    dmv_rsp_if rsp_ch ();

    dense_matrix_vector_mac_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // predictor state: own copy of both stores and the two size registers
    // ------------------------------------------------------------------------
    logic signed [dmv_pkg::VALUE_BITS-1:0] matrix_model [dmv_pkg::DEPTH];
    logic signed [dmv_pkg::VALUE_BITS-1:0] vector_model [dmv_pkg::MAX_DIM];
    logic [dmv_pkg::CFG_BITS-1:0] rows_cfg = dmv_pkg::CFG_BITS'(dmv_pkg::SIZE_RESET);
    logic [dmv_pkg::CFG_BITS-1:0] cols_cfg = dmv_pkg::CFG_BITS'(dmv_pkg::SIZE_RESET);

    // vector elements that the stimulus has already queued a load for, so no row
    // product ever touches an element that was never written
    logic [dmv_pkg::MAX_DIM-1:0]  vec_planned = '0;

    mac_word_t   word_queue [$];        // words waiting for the driver
    mac_result_t expected_results [$];  // predicted response words, oldest first

    int cmd_accepts   = 0;
    int rsp_accepts   = 0;
    int failures      = 0;
    int stall_cycles  = 0;
    int index_errors  = 0;
    int size_settings = 0;
    int kind_seen [4] = '{0, 0, 0, 0};
    int hold_requests = 0;

    // driver holds a word on the channel until it is taken
    logic cmd_busy = 1'b0;

    // size register as the block uses it, clamped to 1..MAX_DIM
    function automatic int dim_in_use(input logic [dmv_pkg::CFG_BITS-1:0] v);
        if (v == '0)
            return 1;
        if (v > dmv_pkg::CFG_BITS'(dmv_pkg::MAX_DIM))
            return dmv_pkg::MAX_DIM;
        return int'(v);
    endfunction

    function automatic logic signed [dmv_pkg::VALUE_BITS-1:0] clamp_q(
        input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (dmv_pkg::VALUE_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi[dmv_pkg::VALUE_BITS-1:0];
        if (v < lo)
            return lo[dmv_pkg::VALUE_BITS-1:0];
        return v[dmv_pkg::VALUE_BITS-1:0];
    endfunction

    // expected response for one accepted word; updates the model stores
    function automatic mac_result_t predict_word(input mac_word_t w);
        mac_result_t        r;
        int                 nr;
        int                 nc;
        int                 addr;
        int                 j;
        logic signed [63:0] sum;
        logic signed [63:0] prod;
        nr = dim_in_use(rows_cfg);
        nc = dim_in_use(cols_cfg);
        r.value = '0;
        r.err = 1'b0;
        case (w.kind)
            dmv_pkg::KIND_ACC, dmv_pkg::KIND_READ:
            begin
                if (w.row >= nr || w.col >= nc)
                    r.err = 1'b1;
                else
                begin
                    addr = int'(w.row) * nc + int'(w.col);
                    if (w.kind == dmv_pkg::KIND_ACC)
                    begin
                        sum = matrix_model[addr];
                        sum = sum + w.value;
                        matrix_model[addr] = clamp_q(sum);
                    end
                    r.value = matrix_model[addr];
                end
            end
            dmv_pkg::KIND_VEC:
            begin
                if (w.col >= nc)
                    r.err = 1'b1;
                else
                begin
                    vector_model[w.col] = w.value;
                    r.value = w.value;
                end
            end
            default:
            begin
                if (w.row >= nr)
                    r.err = 1'b1;
                else
                begin
                    // skip_diagonal drops both the addend and the term at col == row
                    if (w.skip)
                        sum = 64'sd0;
                    else
                        sum = w.value;
                    for (j = 0; j < nc; j++)
                    begin
                        if (!(w.skip && j == int'(w.row)))
                        begin
                            prod = matrix_model[int'(w.row) * nc + j];
                            prod = prod * vector_model[j];
                            // arithmetic shift of the exact product: floor
                            sum = sum + (prod >>> dmv_pkg::FRAC_BITS);
                        end
                    end
                    r.value = clamp_q(sum);
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_word(input dmv_pkg::kind_t k, input int r, input int c,
                              input logic [dmv_pkg::FIELD_BITS-1:0] v, input logic s);
        mac_word_t w;
        w.kind  = k;
        w.row   = dmv_pkg::IDX_BITS'(r);
        w.col   = dmv_pkg::IDX_BITS'(c);
        w.value = v;
        w.skip  = s;
        if (k == dmv_pkg::KIND_VEC && c < dim_in_use(cols_cfg))
            vec_planned[c] = 1'b1;
        word_queue.push_back(w);
    endtask

    // mix of extremes, small q16.16 values (about +-2.0) and raw random bits
    function automatic logic [dmv_pkg::FIELD_BITS-1:0] draw_q16();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4, 5: return dmv_pkg::FIELD_BITS'($urandom_range(0, 'h3ffff)) -
                            dmv_pkg::FIELD_BITS'('h20000);
            default: return $urandom;
        endcase
    endfunction

    // one random command word for the current sizes; a row product that
    // would read an unloaded vector element becomes a load of that element
    task automatic queue_random_word();
        int             nr;
        int             nc;
        int             pick;
        int             r;
        int             c;
        int             j;
        dmv_pkg::kind_t k;
        logic           s;
        nr   = dim_in_use(rows_cfg);
        nc   = dim_in_use(cols_cfg);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            k = dmv_pkg::KIND_ACC;
        else if (pick < 50)
            k = dmv_pkg::KIND_READ;
        else if (pick < 68)
            k = dmv_pkg::KIND_VEC;
        else
            k = dmv_pkg::KIND_ROW;
        // mostly in-range indices, now and then anything the field allows
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, dmv_pkg::MAX_DIM - 1) :
                                          $urandom_range(0, nr - 1);
        c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, dmv_pkg::MAX_DIM - 1) :
                                          $urandom_range(0, nc - 1);
        s = 1'($urandom_range(0, 1));
        if (k == dmv_pkg::KIND_ROW && r < nr)
        begin
            for (j = 0; j < nc; j++)
            begin
                if (k == dmv_pkg::KIND_ROW && !vec_planned[j] && !(s && j == r))
                begin
                    k = dmv_pkg::KIND_VEC;
                    c = j;
                end
            end
        end
        queue_word(k, r, c, draw_q16(), s);
    endtask

    // apb write: setup cycle, then access cycle; pready is always high
    task automatic write_size(input logic [0:0] reg_idx,
                              input logic [dmv_pkg::CFG_BITS-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= dmv_pkg::APB_DATA_BITS'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == dmv_pkg::REG_ROWS)
            rows_cfg = value;
        else
            cols_cfg = value;
    endtask

    task automatic set_sizes(input logic [dmv_pkg::CFG_BITS-1:0] nrows,
                             input logic [dmv_pkg::CFG_BITS-1:0] ncols);
        write_size(dmv_pkg::REG_ROWS, nrows);
        write_size(dmv_pkg::REG_COLS, ncols);
        size_settings++;
    endtask

    // sender pause: nothing queued, nothing offered, nothing still expected
    task automatic wait_drained();
        while (word_queue.size() != 0 || cmd_busy || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic record_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX)
            $display("mismatch: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // command driver: pops words, holds valid until the word is taken
    // ------------------------------------------------------------------------
    logic      cmd_burst = 1'b0;
    int        cmd_gap   = 0;
    int        cmd_seen  = 0;
    mac_word_t next_word;

    always @(negedge clk)
    begin
        if (cmd_busy && cmd_accepts != cmd_seen)
        begin
            cmd_busy = 1'b0;
            cmd_seen = cmd_accepts;
            // switch now and then between gapped traffic and back-to-back words
            if ($urandom_range(0, 29) == 0)
                cmd_burst = !cmd_burst;
            cmd_gap = cmd_burst ? 0 : $urandom_range(0, GAP_MAX);
        end
        if (!cmd_busy)
        begin
            if (cmd_gap > 0)
            begin
                cmd_gap--;
                cmd_ch.valid <= 1'b0;
            end
            else if (word_queue.size() != 0)
            begin
                next_word = word_queue.pop_front();
                cmd_ch.kind          <= next_word.kind;
                cmd_ch.row           <= next_word.row;
                cmd_ch.col           <= next_word.col;
                cmd_ch.entry_value   <= next_word.value;
                cmd_ch.skip_diagonal <= next_word.skip;
                cmd_ch.valid         <= 1'b1;
                cmd_busy = 1'b1;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // response receiver: random ready gaps, plus one long hold on request
    // ------------------------------------------------------------------------
    logic rsp_burst   = 1'b0;
    int   rsp_gap     = 0;
    int   rsp_seen    = 0;
    int   hold_served = 0;
    int   hold_left   = 0;

    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (rsp_accepts != rsp_seen)
        begin
            rsp_seen = rsp_accepts;
            if ($urandom_range(0, 29) == 0)
                rsp_burst = !rsp_burst;
            rsp_gap = rsp_burst ? 0 : $urandom_range(0, GAP_MAX);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (rsp_gap > 0)
        begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // monitor: predict on command accept, check on response accept, watchdog
    // ------------------------------------------------------------------------
    mac_word_t   taken_word;
    mac_result_t want;
    logic        word_moved;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            word_moved = psel && penable && pwrite && pready;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                taken_word.kind  = dmv_pkg::kind_t'(cmd_ch.kind);
                taken_word.row   = cmd_ch.row;
                taken_word.col   = cmd_ch.col;
                taken_word.value = cmd_ch.entry_value;
                taken_word.skip  = cmd_ch.skip_diagonal;
                expected_results.push_back(predict_word(taken_word));
                kind_seen[taken_word.kind]++;
                cmd_accepts++;
                word_moved = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_accepts++;
                word_moved = 1'b1;
                if (rsp_ch.index_error === 1'b1)
                    index_errors++;
                if (expected_results.size() == 0)
                    record_failure($sformatf("response word %0d with nothing expected (%h, %b)",
                                             rsp_accepts, rsp_ch.result_value,
                                             rsp_ch.index_error));
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.result_value !== want.value)
                        record_failure($sformatf("word %0d result_value expected %h got %h",
                                                 rsp_accepts, want.value, rsp_ch.result_value));
                    if (rsp_ch.index_error !== want.err)
                        record_failure($sformatf("word %0d index_error expected %b got %b",
                                                 rsp_accepts, want.err, rsp_ch.index_error));
                end
            end
            if (word_moved)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         stall_cycles, expected_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    int n;
    int p;

    initial
    begin
        // every dut input known from time zero
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.kind          = dmv_pkg::KIND_ACC;
        cmd_ch.row           = '0;
        cmd_ch.col           = '0;
        cmd_ch.entry_value   = '0;
        cmd_ch.skip_diagonal = 1'b0;
        rsp_ch.ready         = 1'b0;
        for (n = 0; n < dmv_pkg::DEPTH; n++)
            matrix_model[n] = '0;
        for (n = 0; n < dmv_pkg::MAX_DIM; n++)
            vector_model[n] = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part on a 4x4 window so index errors are reachable
        set_sizes(5'd4, 5'd4);
        // vector extremes, then an element with odd low bits for floor rounding
        queue_word(dmv_pkg::KIND_VEC, 0, 0, 32'h7fff_ffff, 1'b0);
        queue_word(dmv_pkg::KIND_VEC, 0, 1, 32'h8000_0000, 1'b1);
        queue_word(dmv_pkg::KIND_VEC, 0, 2, 32'h0001_0000, 1'b0);
        queue_word(dmv_pkg::KIND_VEC, 0, 3, 32'hfffe_8001, 1'b0);
        queue_word(dmv_pkg::KIND_VEC, 0, 4, 32'h1234_5678, 1'b0);   // vector index past cols
        // accumulate into saturation both ways
        queue_word(dmv_pkg::KIND_ACC, 0, 0, 32'h7fff_ffff, 1'b0);
        queue_word(dmv_pkg::KIND_ACC, 0, 0, 32'h7fff_ffff, 1'b0);
        queue_word(dmv_pkg::KIND_ACC, 0, 1, 32'h8000_0000, 1'b1);
        queue_word(dmv_pkg::KIND_ACC, 0, 1, 32'h8000_0000, 1'b0);
        queue_word(dmv_pkg::KIND_ACC, 1, 0, 32'h8000_0000, 1'b0);
        queue_word(dmv_pkg::KIND_ACC, 3, 3, 32'h0000_8001, 1'b0);
        queue_word(dmv_pkg::KIND_ACC, 4, 0, 32'h0000_0001, 1'b0);   // row past rows
        queue_word(dmv_pkg::KIND_ACC, 0, 15, 32'h0000_0001, 1'b0);  // col past cols
        // reads: written, never written, out of range
        queue_word(dmv_pkg::KIND_READ, 0, 0, 32'hffff_ffff, 1'b1);
        queue_word(dmv_pkg::KIND_READ, 2, 2, 32'h0000_0000, 1'b0);
        queue_word(dmv_pkg::KIND_READ, 15, 15, 32'h0000_0000, 1'b0);
        queue_word(dmv_pkg::KIND_READ, 1, 0, 32'h0000_0000, 1'b0);
        // row products: saturate high, skip with ignored addend, saturate low,
        // skip that leaves nothing, inexact negative term, bare addend, bad row
        queue_word(dmv_pkg::KIND_ROW, 0, 0, 32'h0000_0000, 1'b0);
        queue_word(dmv_pkg::KIND_ROW, 0, 7, 32'h7fff_ffff, 1'b1);
        queue_word(dmv_pkg::KIND_ROW, 1, 0, 32'h0000_0000, 1'b0);
        queue_word(dmv_pkg::KIND_ROW, 3, 0, 32'h0001_2345, 1'b1);
        queue_word(dmv_pkg::KIND_ROW, 3, 0, 32'h0005_0000, 1'b0);
        queue_word(dmv_pkg::KIND_ROW, 2, 0, 32'h8000_0000, 1'b0);
        queue_word(dmv_pkg::KIND_ROW, 15, 0, 32'h0000_0000, 1'b0);
        wait_drained();

        // random phases over full, minimal, clamped and random sizes
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0:       set_sizes(5'd16, 5'd16);
                1:       set_sizes(5'd1, 5'd1);
                2:       set_sizes(5'd0, 5'd31);
                3:       set_sizes(5'd31, 5'd0);
                4:       set_sizes(5'd16, 5'd16);
                default: set_sizes(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            endcase
            for (n = 0; n < ((p == 0 || p == 4) ? 150 : 100); n++)
                queue_random_word();
            // first phase: park the response side so the block backs up its input
            if (p == 0)
                hold_requests++;
            // mid-phase sender pause until everything has come back
            if (p == 4)
            begin
                wait_drained();
                for (n = 0; n < 20; n++)
                    queue_random_word();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            record_failure($sformatf("%0d expected results never arrived",
                                     expected_results.size()));

        $display("covered %0d words: %0d accumulate, %0d read, %0d vector load, %0d row product",
                 cmd_accepts, kind_seen[dmv_pkg::KIND_ACC], kind_seen[dmv_pkg::KIND_READ],
                 kind_seen[dmv_pkg::KIND_VEC], kind_seen[dmv_pkg::KIND_ROW]);
        $display("%0d index errors over %0d size settings, %0d failures",
                 index_errors, size_settings, failures);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
